FILE: design/teh_pkg.sv
// ----------------------------------------------------------------------------
// teh_pkg - shared types and constants
// Field widths, command and select codes, and the sequencer state type of the
// transfer entropy joint histogram unit.
// ----------------------------------------------------------------------------
package teh_pkg;

	// histogram depths, fixed by the widths of the result codes
	localparam int STATE_BINS     = 4096;
	localparam int HISTORY_BINS   = 256;
	localparam int SOURCE_BINS    = 1024;
	localparam int PREDICATE_BINS = 1024;

	localparam int STATE_AW     = $clog2(STATE_BINS);
	localparam int HISTORY_AW   = $clog2(HISTORY_BINS);
	localparam int SOURCE_AW    = $clog2(SOURCE_BINS);
	localparam int PREDICATE_AW = $clog2(PREDICATE_BINS);

	// request fields
	localparam int CMD_W     = 2;
	localparam int SYM_W     = 8;
	localparam int SEL_W     = 2;
	localparam int BIN_IDX_W = 12;

	// result fields
	localparam int STATE_CODE_W = 12;
	localparam int HIST_CODE_W  = 8;
	localparam int SRC_CODE_W   = 10;
	localparam int PRED_CODE_W  = 10;
	localparam int BIN_COUNT_W  = 32;

	// stream packing
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = CMD_W;
	localparam int OUT_USER_W = 1;
	localparam int OUT_USED_W = 1 + STATE_CODE_W + HIST_CODE_W + SRC_CODE_W + PRED_CODE_W
		+ BIN_COUNT_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;
	localparam int BIN_LSB    = OUT_USED_W - BIN_COUNT_W;

	// configuration
	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 1;
	localparam int BASE_W    = 3;
	localparam int K_W       = 3;
	localparam int SEEN_W    = 3;
	localparam int STEP_W    = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE    = 1'd0,
		REG_HISTORY = 1'd1
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [SEL_W-1:0] {
		HIST_STATE     = 2'd0,
		HIST_HISTORY   = 2'd1,
		HIST_SOURCE    = 2'd2,
		HIST_PREDICATE = 2'd3
	} hist_sel_t;

	// Horner chains run one after the other through the shared unit
	typedef enum logic [1:0] {
		CH_HISTORY   = 2'd0,
		CH_PREDICATE = 2'd1,
		CH_SOURCE    = 2'd2,
		CH_STATE     = 2'd3
	} chain_t;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'd0,
		ST_IDLE   = 3'd1,
		ST_CODE   = 3'd2,
		ST_READ   = 3'd3,
		ST_UPDATE = 3'd4,
		ST_DONE   = 3'd5
	} state_t;

	typedef struct packed {
		logic step;
		logic first;
	} mac_ctrl_t;

endpackage

FILE: design/teh_mac.sv
// ----------------------------------------------------------------------------
// teh_mac - shared multiply-add unit
// One Horner step per cycle while ctrl.step is high: acc <= acc * base + digit.
// ----------------------------------------------------------------------------
module teh_mac import teh_pkg::*; #(
	parameter int ACC_W = 12,
	parameter int DIG_W = 2
) (
	input  logic              clk,
	input  mac_ctrl_t         ctrl,
	input  logic [BASE_W-1:0] base,
	input  logic [DIG_W-1:0]  digit,
	output logic [ACC_W-1:0]  sum
);

	localparam int PROD_W = ACC_W + BASE_W;

	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  acc_in;
	logic [PROD_W-1:0] prod;

	// first step of a chain starts from zero
	assign acc_in = ctrl.first ? '0 : acc_q;
	assign prod   = PROD_W'(acc_in) * PROD_W'(base);
	assign sum    = ACC_W'(prod + PROD_W'(digit));

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			acc_q <= sum;
		end
	end

endmodule

FILE: design/teh_bin_ram.sv
// ----------------------------------------------------------------------------
// teh_bin_ram - histogram counter memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module teh_bin_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/transfer_entropy_histogram_unit.sv
// ----------------------------------------------------------------------------
// transfer_entropy_histogram_unit - joint histogram builder for transfer entropy
// Counted sample: four Horner chains (k = history length) of k, k+1, k+1 and
//   k+2 steps through one multiply-add, then a counter read and update.
// Warm-up, bad-symbol and unknown requests go straight to the result state.
// Bin read: read and update states. Clear: sweep of the counter memories, then the result.
// Reset (arst_n low, async) starts the same sweep; tready stays low.
// One request in flight at a time; ready returns once the result is registered.
// ----------------------------------------------------------------------------
module transfer_entropy_histogram_unit import teh_pkg::*; #(
	parameter int MAX_BASE    = 4,
	parameter int MAX_HISTORY = 4,
	parameter int COUNT_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// request stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// new_series, target_value, source_value, which_histogram, bin_index
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// command
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// encoding_error, state_code, history_code, source_code, predicate_code, bin_count
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// code_valid
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	// one symbol digit; the effective base never exceeds MAX_BASE
	localparam int DIG_W     = $clog2(MAX_BASE);
	// widest code is b^(k+2) - 1
	localparam int CODE_W    = DIG_W * (MAX_HISTORY + 2);
	localparam int WIN_IDX_W = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
	// range compares need room for the largest depth itself
	localparam int CMP_W     = ((CODE_W > BIN_IDX_W) ? CODE_W : BIN_IDX_W) + 1;

	// ------------------------------------------------------------------
	// Configuration and effective (clamped) values
	// ------------------------------------------------------------------
	logic [CFG_W-1:0]  base_q;
	logic [CFG_W-1:0]  k_q;
	logic [BASE_W-1:0] eff_b;
	logic [K_W-1:0]    eff_k;

	always_comb begin
		if (base_q < 3'd2) begin
			eff_b = 3'd2;
		end else if (int'(base_q) > MAX_BASE) begin
			eff_b = BASE_W'(MAX_BASE);
		end else begin
			eff_b = base_q;
		end
	end

	always_comb begin
		if (k_q < 3'd1) begin
			eff_k = 3'd1;
		end else if (int'(k_q) > MAX_HISTORY) begin
			eff_k = K_W'(MAX_HISTORY);
		end else begin
			eff_k = k_q;
		end
	end

	// ------------------------------------------------------------------
	// Request decode
	// ------------------------------------------------------------------
	logic                 accept;
	cmd_t                 in_cmd;
	logic                 in_new;
	logic [SYM_W-1:0]     in_x;
	logic [SYM_W-1:0]     in_y;
	hist_sel_t            in_sel;
	logic [BIN_IDX_W-1:0] in_bin;
	logic                 bad_sym;
	logic [SEEN_W-1:0]    seen_q;
	logic [SEEN_W-1:0]    seen_eff;
	logic                 will_count;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign in_cmd   = cmd_t'(s_axis_tuser[CMD_W-1:0]);
	assign in_new   = s_axis_tdata[0];
	assign in_x     = s_axis_tdata[1 +: SYM_W];
	assign in_y     = s_axis_tdata[1 + SYM_W +: SYM_W];
	assign in_sel   = hist_sel_t'(s_axis_tdata[1 + 2*SYM_W +: SEL_W]);
	assign in_bin   = s_axis_tdata[1 + 2*SYM_W + SEL_W +: BIN_IDX_W];

	// a symbol at or above the base poisons the sample
	assign bad_sym  = (in_x >= SYM_W'(eff_b)) || (in_y >= SYM_W'(eff_b));
	assign seen_eff = in_new ? '0 : seen_q;
	assign will_count = (seen_eff >= SEEN_W'(eff_k));

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	state_t               state_q, state_d;
	logic                 error_q;
	logic [DIG_W-1:0]     win_q [MAX_HISTORY];   // newest at index 0
	logic [DIG_W-1:0]     prev_q;
	logic [STATE_AW-1:0]  sweep_q;
	logic                 clr_resp_q;
	chain_t               chain_q;
	logic [STEP_W-1:0]    step_q;
	logic                 counted_q;
	logic                 out_valid_q;

	// request payload
	cmd_t                 cmd_q;
	logic [DIG_W-1:0]     x_q;
	logic [DIG_W-1:0]     y_q;
	hist_sel_t            sel_q;
	logic [BIN_IDX_W-1:0] bin_idx_q;
	logic [BIN_COUNT_W-1:0] bin_q;
	logic [CODE_W-1:0]    hist_code_q;
	logic [CODE_W-1:0]    pred_code_q;
	logic [CODE_W-1:0]    src_code_q;
	logic [CODE_W-1:0]    state_code_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	// ------------------------------------------------------------------
	// Horner sequencing. Each chain feeds its lead digits, then the window
	// oldest first:
	//   history   : w[k-1] .. w[0]
	//   predicate : x, w[k-1] .. w[0]
	//   source    : ps, w[k-1] .. w[0]
	//   state     : ps, x, w[k-1] .. w[0]
	// ------------------------------------------------------------------
	logic [1:0]          lead;
	logic [STEP_W-1:0]   chain_len;
	logic                chain_last;
	logic [STEP_W-1:0]   win_idx;
	logic [DIG_W-1:0]    lead_digit;
	logic [DIG_W-1:0]    digit;
	logic [CODE_W-1:0]   mac_sum;
	mac_ctrl_t           mac_ctrl;

	always_comb begin
		case (chain_q)
			CH_HISTORY:   lead = 2'd0;
			CH_PREDICATE: lead = 2'd1;
			CH_SOURCE:    lead = 2'd1;
			CH_STATE:     lead = 2'd2;
			default:      lead = 2'd0;
		endcase
	end

	always_comb begin
		case (chain_q)
			CH_PREDICATE: lead_digit = x_q;
			CH_SOURCE:    lead_digit = prev_q;
			CH_STATE:     lead_digit = (step_q == '0) ? prev_q : x_q;
			default:      lead_digit = '0;
		endcase
	end

	assign chain_len  = STEP_W'(eff_k) + STEP_W'(lead);
	assign chain_last = (step_q == chain_len - STEP_W'(1));
	assign win_idx    = chain_len - STEP_W'(1) - step_q;
	assign digit      = (step_q < STEP_W'(lead)) ? lead_digit : win_q[win_idx[WIN_IDX_W-1:0]];

	teh_mac #(
		.ACC_W (CODE_W),
		.DIG_W (DIG_W)
	) u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.base  (eff_b),
		.digit (digit),
		.sum   (mac_sum)
	);

	// ------------------------------------------------------------------
	// Counter memories. Reads use the codes for a sample, the bin index
	// for a read request; the increment writes back to the same address.
	// ------------------------------------------------------------------
	logic                  clearing;
	logic                  is_read;
	logic [CMP_W-1:0]      key_st, key_hi, key_sr, key_pr;
	logic                  ok_st, ok_hi, ok_sr, ok_pr;
	logic [STATE_AW-1:0]   addr_st;
	logic [HISTORY_AW-1:0] addr_hi;
	logic [SOURCE_AW-1:0]  addr_sr;
	logic [PREDICATE_AW-1:0] addr_pr;
	logic [COUNT_BITS-1:0] rd_st, rd_hi, rd_sr, rd_pr;
	logic [COUNT_BITS-1:0] rd_sel;
	logic                  we_st, we_hi, we_sr, we_pr;
	logic                  bump;

	assign clearing = (state_q == ST_CLEAR);
	assign is_read  = (cmd_q == CMD_READ);

	assign key_st = is_read ? CMP_W'(bin_idx_q) : CMP_W'(state_code_q);
	assign key_hi = is_read ? CMP_W'(bin_idx_q) : CMP_W'(hist_code_q);
	assign key_sr = is_read ? CMP_W'(bin_idx_q) : CMP_W'(src_code_q);
	assign key_pr = is_read ? CMP_W'(bin_idx_q) : CMP_W'(pred_code_q);

	// codes or bins past a histogram's depth are neither counted nor read
	assign ok_st = key_st < CMP_W'(STATE_BINS);
	assign ok_hi = key_hi < CMP_W'(HISTORY_BINS);
	assign ok_sr = key_sr < CMP_W'(SOURCE_BINS);
	assign ok_pr = key_pr < CMP_W'(PREDICATE_BINS);

	// sweep address during clear; all memories share the low bits
	assign addr_st = clearing ? sweep_q : STATE_AW'(key_st);
	assign addr_hi = clearing ? HISTORY_AW'(sweep_q) : HISTORY_AW'(key_hi);
	assign addr_sr = clearing ? SOURCE_AW'(sweep_q) : SOURCE_AW'(key_sr);
	assign addr_pr = clearing ? PREDICATE_AW'(sweep_q) : PREDICATE_AW'(key_pr);

	assign bump  = (state_q == ST_UPDATE) && counted_q;
	assign we_st = clearing || (bump && ok_st);
	assign we_hi = clearing || (bump && ok_hi);
	assign we_sr = clearing || (bump && ok_sr);
	assign we_pr = clearing || (bump && ok_pr);

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	teh_bin_ram #(.DEPTH(STATE_BINS), .WIDTH(COUNT_BITS)) u_state_ram (
		.clk     (clk),
		.wr_en   (we_st),
		.wr_addr (addr_st),
		.wr_data (clearing ? '0 : sat_inc(rd_st)),
		.rd_addr (addr_st),
		.rd_data (rd_st)
	);

	teh_bin_ram #(.DEPTH(HISTORY_BINS), .WIDTH(COUNT_BITS)) u_history_ram (
		.clk     (clk),
		.wr_en   (we_hi),
		.wr_addr (addr_hi),
		.wr_data (clearing ? '0 : sat_inc(rd_hi)),
		.rd_addr (addr_hi),
		.rd_data (rd_hi)
	);

	teh_bin_ram #(.DEPTH(SOURCE_BINS), .WIDTH(COUNT_BITS)) u_source_ram (
		.clk     (clk),
		.wr_en   (we_sr),
		.wr_addr (addr_sr),
		.wr_data (clearing ? '0 : sat_inc(rd_sr)),
		.rd_addr (addr_sr),
		.rd_data (rd_sr)
	);

	teh_bin_ram #(.DEPTH(PREDICATE_BINS), .WIDTH(COUNT_BITS)) u_predicate_ram (
		.clk     (clk),
		.wr_en   (we_pr),
		.wr_addr (addr_pr),
		.wr_data (clearing ? '0 : sat_inc(rd_pr)),
		.rd_addr (addr_pr),
		.rd_data (rd_pr)
	);

	always_comb begin
		case (sel_q)
			HIST_STATE:     rd_sel = ok_st ? rd_st : '0;
			HIST_HISTORY:   rd_sel = ok_hi ? rd_hi : '0;
			HIST_SOURCE:    rd_sel = ok_sr ? rd_sr : '0;
			HIST_PREDICATE: rd_sel = ok_pr ? rd_pr : '0;
			default:        rd_sel = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	logic out_load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (&sweep_q) begin
					state_d = clr_resp_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_SAMPLE: state_d = (!bad_sym && will_count) ? ST_CODE : ST_DONE;
						CMD_READ:   state_d = ST_READ;
						CMD_CLEAR:  state_d = ST_CLEAR;
						CMD_NONE:   state_d = ST_DONE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_CODE: begin
				if (chain_last && (chain_q == CH_STATE)) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready  = (state_q == ST_IDLE);
		mac_ctrl.step  = (state_q == ST_CODE);
		mac_ctrl.first = (step_q == '0);
		out_load       = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	logic win_shift;
	logic [DIG_W-1:0] shift_x;
	logic [DIG_W-1:0] shift_y;

	// warm-up samples shift at accept; counted ones after their update
	assign win_shift = (accept && (in_cmd == CMD_SAMPLE) && !bad_sym && !will_count) || bump;
	assign shift_x   = (state_q == ST_IDLE) ? in_x[DIG_W-1:0] : x_q;
	assign shift_y   = (state_q == ST_IDLE) ? in_y[DIG_W-1:0] : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			clr_resp_q  <= 1'b0;
			base_q      <= 3'd2;
			k_q         <= 3'd1;
			seen_q      <= '0;
			error_q     <= 1'b0;
			prev_q      <= '0;
			chain_q     <= CH_HISTORY;
			step_q      <= '0;
			counted_q   <= 1'b0;
			cmd_q       <= CMD_NONE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_HISTORY; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (clearing) begin
				sweep_q <= sweep_q + STATE_AW'(1);
			end

			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_BASE:    base_q <= cfg_data;
					REG_HISTORY: k_q    <= cfg_data;
					default:     ;
				endcase
			end

			if (accept) begin
				cmd_q      <= in_cmd;
				clr_resp_q <= (in_cmd == CMD_CLEAR);
				counted_q  <= (in_cmd == CMD_SAMPLE) && !bad_sym && will_count;
				chain_q    <= CH_HISTORY;
				step_q     <= '0;
			end else if (state_q == ST_CODE) begin
				if (chain_last) begin
					step_q  <= '0;
					chain_q <= chain_t'(chain_q + 2'd1);
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end

			// window restart: config write wins over sample bookkeeping
			if (cfg_we) begin
				seen_q <= '0;
			end else if (accept && (in_cmd == CMD_SAMPLE)) begin
				if (bad_sym) begin
					seen_q  <= '0;
					error_q <= 1'b1;
				end else if (will_count) begin
					seen_q <= seen_eff;
				end else begin
					seen_q <= (&seen_eff) ? seen_eff : seen_eff + SEEN_W'(1);
				end
			end else if (bump) begin
				seen_q <= (&seen_q) ? seen_q : seen_q + SEEN_W'(1);
			end

			if (win_shift) begin
				for (int i = MAX_HISTORY - 1; i > 0; i--) begin
					win_q[i] <= win_q[i-1];
				end
				win_q[0] <= shift_x;
				prev_q   <= shift_y;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q       <= in_x[DIG_W-1:0];
			y_q       <= in_y[DIG_W-1:0];
			sel_q     <= in_sel;
			bin_idx_q <= in_bin;
			bin_q     <= '0;
		end

		if (mac_ctrl.step && chain_last) begin
			case (chain_q)
				CH_HISTORY:   hist_code_q  <= mac_sum;
				CH_PREDICATE: pred_code_q  <= mac_sum;
				CH_SOURCE:    src_code_q   <= mac_sum;
				CH_STATE:     state_code_q <= mac_sum;
				default:      ;
			endcase
		end

		if ((state_q == ST_UPDATE) && is_read) begin
			bin_q <= BIN_COUNT_W'(rd_sel);
		end

		if (out_load) begin
			out_user_q <= OUT_USER_W'(counted_q);
			out_data_q <= {
				{OUT_PAD_W{1'b0}},
				bin_q,
				counted_q ? PRED_CODE_W'(pred_code_q)   : PRED_CODE_W'(0),
				counted_q ? SRC_CODE_W'(src_code_q)     : SRC_CODE_W'(0),
				counted_q ? HIST_CODE_W'(hist_code_q)   : HIST_CODE_W'(0),
				counted_q ? STATE_CODE_W'(state_code_q) : STATE_CODE_W'(0),
				error_q
			};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`ifndef NO_ASSERTIONS
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		error_q |=> error_q)
		else $error("encoding error flag dropped");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CODE) |-> (step_q < chain_len))
		else $error("Horner step past chain length");

	a_update_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> ($past(state_q) == ST_READ))
		else $error("counter update without a memory read");

	a_codes_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[BIN_LSB +: BIN_COUNT_W] == '0))
		else $error("counted sample carries a bin count");
`endif

endmodule

FILE: dv/teh_histogram_checker.sv
// ----------------------------------------------------------------------------
// teh_histogram_checker - result predictor and comparator
// Watches the configuration port and both streams of the transfer entropy
// histogram unit, keeps its own copy of the window and the four count tables,
// and compares every result against the oldest predicted one.
// ----------------------------------------------------------------------------
module teh_histogram_checker import teh_pkg::*; #(
	parameter int MAX_BASE    = 4,
	parameter int MAX_HISTORY = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [OUT_USER_W-1:0] m_axis_tuser,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// same bit order as {tuser, tdata} without the padding
	typedef struct packed {
		logic                    code_valid;
		logic [BIN_COUNT_W-1:0]  bin_count;
		logic [PRED_CODE_W-1:0]  predicate_code;
		logic [SRC_CODE_W-1:0]   source_code;
		logic [HIST_CODE_W-1:0]  history_code;
		logic [STATE_CODE_W-1:0] state_code;
		logic                    encoding_error;
	} reply_t;

	logic [CFG_W-1:0]       base_reg;
	logic [CFG_W-1:0]       length_reg;
	logic [SYM_W-1:0]       window [MAX_HISTORY];
	logic [SYM_W-1:0]       last_source;
	int                     seen;
	logic                   sticky_error;
	logic [BIN_COUNT_W-1:0] state_tbl [STATE_BINS];
	logic [BIN_COUNT_W-1:0] history_tbl [HISTORY_BINS];
	logic [BIN_COUNT_W-1:0] source_tbl [SOURCE_BINS];
	logic [BIN_COUNT_W-1:0] predicate_tbl [PREDICATE_BINS];
	reply_t                 replies_due [$];

	task automatic clear_tables();
		foreach (state_tbl[i]) state_tbl[i] = '0;
		foreach (history_tbl[i]) history_tbl[i] = '0;
		foreach (source_tbl[i]) source_tbl[i] = '0;
		foreach (predicate_tbl[i]) predicate_tbl[i] = '0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic tally_request(cmd_t cmd, logic [IN_DATA_W-1:0] data);
		reply_t                 r;
		logic                   pad;
		logic                   ns;
		logic [SYM_W-1:0]       x;
		logic [SYM_W-1:0]       y;
		logic [SEL_W-1:0]       sel;
		logic [BIN_IDX_W-1:0]   bin;
		int                     b, k, h, bk, pred, src, st, i;
		r = '0;
		{pad, bin, sel, y, x, ns} = data;
		case (cmd)
			CMD_SAMPLE: begin
				b = (base_reg < 2) ? 2 : (base_reg > MAX_BASE) ? MAX_BASE : int'(base_reg);
				k = (length_reg < 1) ? 1 :
					(length_reg > MAX_HISTORY) ? MAX_HISTORY : int'(length_reg);
				if (ns)
					seen = 0;
				if (x >= b || y >= b) begin
					// bad symbol: flag it, restart, keep old window contents
					sticky_error = 1'b1;
					seen = 0;
				end else begin
					if (seen >= k) begin
						h = 0;
						bk = 1;
						for (i = 0; i < k; i++) begin
							h += int'(window[i]) * bk;
							bk *= b;
						end
						pred = h + int'(x) * bk;
						src = h + int'(last_source) * bk;
						st = pred + int'(last_source) * bk * b;
						if (st < STATE_BINS && state_tbl[st] != '1)
							state_tbl[st]++;
						if (h < HISTORY_BINS && history_tbl[h] != '1)
							history_tbl[h]++;
						if (src < SOURCE_BINS && source_tbl[src] != '1)
							source_tbl[src]++;
						if (pred < PREDICATE_BINS && predicate_tbl[pred] != '1)
							predicate_tbl[pred]++;
						r.code_valid = 1'b1;
						r.state_code = STATE_CODE_W'(st);
						r.history_code = HIST_CODE_W'(h);
						r.source_code = SRC_CODE_W'(src);
						r.predicate_code = PRED_CODE_W'(pred);
					end
					for (i = MAX_HISTORY - 1; i > 0; i--)
						window[i] = window[i - 1];
					window[0] = x;
					last_source = y;
					if (seen < 7)
						seen++;
				end
			end
			CMD_READ: begin
				case (hist_sel_t'(sel))
					HIST_STATE: if (bin < STATE_BINS) r.bin_count = state_tbl[bin];
					HIST_HISTORY: if (bin < HISTORY_BINS) r.bin_count = history_tbl[bin];
					HIST_SOURCE: if (bin < SOURCE_BINS) r.bin_count = source_tbl[bin];
					default: if (bin < PREDICATE_BINS) r.bin_count = predicate_tbl[bin];
				endcase
			end
			CMD_CLEAR: clear_tables();
			default: ;
		endcase
		r.encoding_error = sticky_error;
		replies_due.push_back(r);
	endtask

	task automatic check_reply(reply_t got);
		reply_t want;
		if (replies_due.size() == 0) begin
			report_mismatch("unexpected result", got.bin_count, 0);
			return;
		end
		want = replies_due.pop_front();
		if (got.code_valid != want.code_valid)
			report_mismatch("code_valid", got.code_valid, want.code_valid);
		if (got.encoding_error != want.encoding_error)
			report_mismatch("encoding_error", got.encoding_error, want.encoding_error);
		if (got.state_code != want.state_code)
			report_mismatch("state_code", got.state_code, want.state_code);
		if (got.history_code != want.history_code)
			report_mismatch("history_code", got.history_code, want.history_code);
		if (got.source_code != want.source_code)
			report_mismatch("source_code", got.source_code, want.source_code);
		if (got.predicate_code != want.predicate_code)
			report_mismatch("predicate_code", got.predicate_code, want.predicate_code);
		if (got.bin_count != want.bin_count)
			report_mismatch("bin_count", got.bin_count, want.bin_count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = 3'd2;
			length_reg = 3'd1;
			foreach (window[i]) window[i] = '0;
			last_source = '0;
			seen = 0;
			sticky_error = 1'b0;
			clear_tables();
			replies_due.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BASE)
					base_reg = cfg_data;
				else
					length_reg = cfg_data;
				seen = 0;
			end
			// a result never shares an edge with its own request
			if (m_axis_tvalid && m_axis_tready)
				check_reply({m_axis_tuser[0], m_axis_tdata[OUT_USED_W-1:0]});
			if (s_axis_tvalid && s_axis_tready)
				tally_request(cmd_t'(s_axis_tuser), s_axis_tdata);
			pending = replies_due.size();
		end
	end

endmodule

FILE: dv/transfer_entropy_histogram_unit_tb.sv
// ----------------------------------------------------------------------------
// transfer_entropy_histogram_unit_tb - stimulus and verdict
// Drives directed then random requests through the histogram unit under
// several base and history length settings, with random gaps on the request
// side and random stalls on the result side; the checker does the comparing.
// ----------------------------------------------------------------------------
module transfer_entropy_histogram_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import teh_pkg::*;

	localparam int MAX_BASE    = 4;
	localparam int MAX_HISTORY = 4;
	// slowest run covers the reset sweep, ~1800 requests and a handful of clears;
	// the limit leaves several times that much room
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// new_series, target_value, source_value, which_histogram, bin_index
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// command
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// encoding_error, state_code, history_code, source_code, predicate_code, bin_count
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// code_valid
	logic [OUT_USER_W-1:0] m_axis_tuser;

	int errors;
	int pending;
	int cycle_count = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;
	// effective (clamped) settings, used to keep random symbols and bins useful
	int sym_base = 2;
	int hist_len = 1;

	// register values per phase: extremes and out-of-range values included
	int phase_base [6] = '{4, 3, 0, 7, 2, 3};
	int phase_len [6]  = '{4, 2, 7, 0, 3, 4};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	transfer_entropy_histogram_unit #(
		.MAX_BASE    (MAX_BASE),
		.MAX_HISTORY (MAX_HISTORY),
		.COUNT_BITS  (BIN_COUNT_W)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	teh_histogram_checker #(
		.MAX_BASE    (MAX_BASE),
		.MAX_HISTORY (MAX_HISTORY)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending)
	);

	// result-side backpressure: random stall bursts while idling is on
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Present one request at a falling edge, maybe after a short gap, and hold
	// it until a rising edge sees tvalid and tready together. Returns at that
	// edge with tvalid still high, so back-to-back requests keep it high.
	task automatic send_request(cmd_t cmd, logic ns, logic [SYM_W-1:0] tv,
		logic [SYM_W-1:0] sv, hist_sel_t sel, logic [BIN_IDX_W-1:0] bin);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {1'b0, bin, sel, sv, tv, ns};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// sample request; the read-only fields carry noise
	task automatic sample(logic ns, logic [SYM_W-1:0] tv, logic [SYM_W-1:0] sv);
		send_request(CMD_SAMPLE, ns, tv, sv, hist_sel_t'($urandom_range(0, 3)),
			BIN_IDX_W'($urandom));
	endtask

	// drop tvalid and wait until every predicted result has been taken
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BASE)
			sym_base = (value < 2) ? 2 : (value > MAX_BASE) ? MAX_BASE : value;
		else
			hist_len = (value < 1) ? 1 : (value > MAX_HISTORY) ? MAX_HISTORY : value;
	endtask

	// Mostly well-formed samples so the window fills and codes get counted;
	// the rest is reads (aimed at reachable bins most of the time), bad
	// symbols, the unused command and now and then a clear.
	task automatic random_request();
		int pick;
		int digits;
		int span;
		hist_sel_t sel;
		logic [BIN_IDX_W-1:0] bin;
		pick = $urandom_range(0, 999);
		if (pick < 4) begin
			send_request(CMD_CLEAR, 1'($urandom), SYM_W'($urandom), SYM_W'($urandom),
				hist_sel_t'($urandom_range(0, 3)), BIN_IDX_W'($urandom));
		end else if (pick < 20) begin
			send_request(CMD_NONE, 1'($urandom), SYM_W'($urandom), SYM_W'($urandom),
				hist_sel_t'($urandom_range(0, 3)), BIN_IDX_W'($urandom));
		end else if (pick < 150) begin
			sel = hist_sel_t'($urandom_range(0, 3));
			case (sel)
				HIST_STATE: digits = hist_len + 2;
				HIST_HISTORY: digits = hist_len;
				default: digits = hist_len + 1;
			endcase
			span = 1;
			repeat (digits) span *= sym_base;
			if ($urandom_range(0, 7) == 0)
				bin = BIN_IDX_W'($urandom);
			else
				bin = BIN_IDX_W'($urandom_range(0, span - 1));
			send_request(CMD_READ, 1'($urandom), SYM_W'($urandom), SYM_W'($urandom),
				sel, bin);
		end else if (pick < 200) begin
			// full-range symbols, almost always at or above the base
			sample(1'($urandom_range(0, 7) == 0), SYM_W'($urandom), SYM_W'($urandom));
		end else begin
			sample(1'($urandom_range(0, 39) == 0), SYM_W'($urandom_range(0, sym_base - 1)),
				SYM_W'($urandom_range(0, sym_base - 1)));
		end
	endtask

	initial begin
		// reset released at a falling edge; the unit then runs its clearing sweep with
		// tready low, which send_request simply waits out
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ---- directed part, reset settings: base 2, history length 1 ----
		// warm-up sample, then the first counted one
		sample(1'b1, 8'd0, 8'd0);
		sample(1'b0, 8'd1, 8'd1);
		sample(1'b0, 8'd1, 8'd0);
		// bad symbols: target at the base, source at the base, both at max
		sample(1'b0, 8'd2, 8'd0);
		sample(1'b0, 8'd0, 8'd2);
		sample(1'b0, 8'd255, 8'd255);
		// the window restarts after a bad symbol: one warm-up, then counted
		sample(1'b0, 8'd1, 8'd0);
		sample(1'b0, 8'd0, 8'd1);
		// new series in the middle of a run
		sample(1'b1, 8'd1, 8'd1);
		sample(1'b0, 8'd1, 8'd0);
		// one read from each table
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_STATE, 12'd6);
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_HISTORY, 12'd1);
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_SOURCE, 12'd1);
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_PREDICATE, 12'd3);
		// reads past the depth of the smaller tables, and the last state bin
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_HISTORY, 12'd4095);
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_SOURCE, 12'd1024);
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_PREDICATE, 12'd3072);
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_STATE, 12'd4095);
		// unused command with every field busy
		send_request(CMD_NONE, 1'b1, 8'd255, 8'd255, HIST_PREDICATE, 12'd4095);
		// new_series has no effect on read or clear
		send_request(CMD_READ, 1'b1, 8'd0, 8'd0, HIST_STATE, 12'd2);
		send_request(CMD_CLEAR, 1'b1, 8'd0, 8'd0, HIST_STATE, 12'd0);
		send_request(CMD_READ, 1'b0, 8'd0, 8'd0, HIST_PREDICATE, 12'd3);
		// clear keeps the window, so this one is counted straight away
		sample(1'b0, 8'd1, 8'd1);

		// ---- random part, one phase per register setting ----
		foreach (phase_base[p]) begin
			wait_idle();
			if ($urandom_range(0, 1)) begin
				write_reg(REG_BASE, phase_base[p]);
				write_reg(REG_HISTORY, phase_len[p]);
			end else begin
				write_reg(REG_HISTORY, phase_len[p]);
				write_reg(REG_BASE, phase_base[p]);
			end
			idle_on = (p != $size(phase_base) - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stretches with and without gaps, none in the last phase
				if (p != $size(phase_base) - 1 && n % 100 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				random_request();
			end
		end

		wait_idle();
		// leave room for any stray results to show up
		repeat (40) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("transfer_entropy_histogram_unit verification clean");
		else
			$display("transfer_entropy_histogram_unit verification failed");
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("transfer_entropy_histogram_unit verification failed");
		$finish;
	end

endmodule
